// ----- rtl/core/irt_pkg.sv -----
package irt_pkg;

    // Result codes
    localparam logic [1:0] OUT_ACCEPTED = 2'd0;
    localparam logic [1:0] OUT_EXISTING = 2'd1;
    localparam logic [1:0] OUT_CONFLICT = 2'd2;
    localparam logic [1:0] OUT_NOCAP    = 2'd3;

    localparam int          DEF_CAPACITY        = 16;
    localparam logic [3:0]  MAX_PRINCIPAL_BYTES = 4'd8;
    localparam logic [31:0] RETENTION_RESET     = 32'd60000;

    // Stored identity and payload hash of one record
    typedef struct packed {
        logic [63:0] principal;
        logic [3:0]  principal_size;
        logic [63:0] network;
        logic [7:0]  op_class;
        logic [63:0] key;
        logic [63:0] hash_hi;
        logic [63:0] hash_lo;
    } t_rec;

    localparam int REC_W  = $bits(t_rec);
    localparam int TIME_W = 64;

    // Keep the low len bytes of a principal
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/irt_ram.sv -----
module irt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/idempotency_record_table.sv -----
// Flow: an accepted transaction is captured, the record memories are scanned
// entry by entry, then write-back registers the result; an overlong principal
// skips the scan. The single-port scan reads one entry per cycle, and no new
// item is taken until write-back completes, which waits while o_valid stalls.
// Reset: synchronous, active low; clears valid bits, occupancy and control
// state and loads retention_ms with 60000. Record memories are not cleared.
module idempotency_record_table
    import irt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int OW = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [63:0]   i_principal_bytes,
    input  logic [3:0]    i_principal_size,
    input  logic [63:0]   i_network_id,
    input  logic [7:0]    i_op_class,
    input  logic [63:0]   i_request_key,
    input  logic [63:0]   i_hash_hi,
    input  logic [63:0]   i_hash_lo,
    input  logic [63:0]   i_now_time,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_outcome,
    output logic          o_slot_valid,
    output logic [IW-1:0] o_slot_index,
    output logic [OW-1:0] o_occupancy,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [31:0]   i_cfg_retention_ms
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [31:0]   r_ret;
    logic [CAPACITY-1:0] r_valid;
    logic [OW-1:0] r_occ;

    t_rec          r_req;
    logic [63:0]   r_now;
    logic          r_long;
    logic [IW-1:0] r_idx;

    logic          r_hit, r_hit_eq, r_free, r_exp;
    logic [IW-1:0] r_hit_idx, r_free_idx, r_exp_idx;
    logic [63:0]   r_oldest;

    logic          r_out_valid, r_out_slot_valid;
    logic [1:0]    r_out_outcome;
    logic [IW-1:0] r_out_slot;
    logic [OW-1:0] r_out_occ;

    // Memory ports
    logic          rd_en, rec_wr_en, time_wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    t_rec          rd_rec;
    logic [63:0]   rd_time;

    logic          accept, load, ent_ok, match, expired, older;
    logic [63:0]   age;
    logic          is_new;
    logic [IW-1:0] new_idx;

    irt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rec_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_req),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_rec)
    );

    irt_ram #(.WIDTH(TIME_W), .DEPTH(CAPACITY)) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (time_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_now),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_time)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign load        = !r_out_valid || i_ready;

    // Read next entry while the current one is checked
    assign rd_en   = accept || (r_state == S_SCAN);
    assign rd_addr = (r_state == S_SCAN) ? IW'(r_idx + 1'b1) : '0;

    // Check the entry presented by the memories
    assign ent_ok  = r_valid[r_idx];
    assign match   = ent_ok && (rd_rec.network == r_req.network)
                     && (rd_rec.op_class == r_req.op_class)
                     && (rd_rec.key == r_req.key)
                     && (rd_rec.principal_size == r_req.principal_size)
                     && (rd_rec.principal == r_req.principal);
    assign age     = r_now - rd_time;
    assign expired = ent_ok && (age >= {32'd0, r_ret});
    assign older   = !r_exp || (rd_time < r_oldest);

    // Write back: refresh on hit, else store into a free or expired slot
    assign is_new     = !r_long && !r_hit && (r_free || r_exp);
    assign new_idx    = r_free ? r_free_idx : r_exp_idx;
    assign wr_addr    = r_hit ? r_hit_idx : new_idx;
    assign rec_wr_en  = (r_state == S_WRITE) && load && is_new;
    assign time_wr_en = (r_state == S_WRITE) && load && !r_long && (r_hit || is_new);

    // Sequence the scan
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_principal_size > MAX_PRINCIPAL_BYTES) ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == IW'(CAPACITY - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= RETENTION_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_ret <= i_cfg_retention_ms;
            end
            if ((r_state == S_WRITE) && load) begin
                r_out_valid <= 1'b1;
                if (is_new && r_free) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_occ               <= r_occ + 1'b1;
                end
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, scan trackers and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.principal      <= i_principal_bytes & byte_mask(i_principal_size);
            r_req.principal_size <= i_principal_size;
            r_req.network        <= i_network_id;
            r_req.op_class       <= i_op_class;
            r_req.key            <= i_request_key;
            r_req.hash_hi        <= i_hash_hi;
            r_req.hash_lo        <= i_hash_lo;
            r_now                <= i_now_time;
            r_long               <= (i_principal_size > MAX_PRINCIPAL_BYTES);
            r_idx                <= '0;
            r_hit                <= 1'b0;
            r_free               <= 1'b0;
            r_exp                <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= IW'(r_idx + 1'b1);
            if (match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
                r_hit_eq  <= (rd_rec.hash_hi == r_req.hash_hi)
                             && (rd_rec.hash_lo == r_req.hash_lo);
            end
            if (!ent_ok && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (expired && older) begin
                r_exp     <= 1'b1;
                r_exp_idx <= r_idx;
                r_oldest  <= rd_time;
            end
        end
        if ((r_state == S_WRITE) && load) begin
            r_out_occ <= (is_new && r_free) ? OW'(r_occ + 1'b1) : r_occ;
            if (r_long) begin
                r_out_outcome    <= OUT_CONFLICT;
                r_out_slot_valid <= 1'b0;
                r_out_slot       <= '0;
            end else if (r_hit) begin
                r_out_outcome    <= r_hit_eq ? OUT_EXISTING : OUT_CONFLICT;
                r_out_slot_valid <= 1'b1;
                r_out_slot       <= r_hit_idx;
            end else if (is_new) begin
                r_out_outcome    <= OUT_ACCEPTED;
                r_out_slot_valid <= 1'b1;
                r_out_slot       <= new_idx;
            end else begin
                r_out_outcome    <= OUT_NOCAP;
                r_out_slot_valid <= 1'b0;
                r_out_slot       <= '0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_outcome    = r_out_outcome;
    assign o_slot_valid = r_out_slot_valid;
    assign o_slot_index = r_out_slot;
    assign o_occupancy  = r_out_occ;

`ifndef SYNTH
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == OW'($countones(r_valid)))
        else $error("occupancy out of step with valid bits");

    a_wr_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rec_wr_en || time_wr_en) |-> (r_state == S_WRITE))
        else $error("memory write outside write-back");

    a_new_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_slot_valid && (r_out_outcome == OUT_ACCEPTED))
        |-> r_valid[r_out_slot])
        else $error("accepted slot not marked valid");

    a_rec_wr_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_wr_en |-> time_wr_en)
        else $error("record written without its last-use time");
`endif

endmodule
